// ----- rtl/obrc_pkg.sv -----
package obrc_pkg;

  localparam int CAPACITY  = 4096;
  localparam int MAX_DRAIN = 64;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int AVAIL_W = $clog2(CAPACITY + 1);
  localparam int CNT_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CUR_W   = 64;

  localparam int IN_FIELDS_W  = BYTE_W + CUR_W + CNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = BYTE_W + 4 * CUR_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

endpackage

// ----- rtl/obrc_ram.sv -----
module obrc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/overwriting_byte_ring_with_cursors.sv -----
// Push: its result beat waits in ST_PUSH_OUT for a free output register; input is held off.
// Drain: ST_LAP, ST_AVAIL, ST_SETUP, then one byte per cycle while the output is not stalled,
// paced by the single ring memory read port; the input is taken again after the last beat.
// Output register decouples the result side: a beat may wait there while work goes on.
// rst_n (sync, active low) clears the byte count, cursors and control; ring contents
// are not cleared and hold stale data until written.
module overwriting_byte_ring_with_cursors (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // data_byte[7:0], read_cursor[71:8], byte_limit[78:72], zero pad
  input  logic [obrc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_byte[7:0], lost_count[71:8], next_cursor[135:72], bytes_copied[142:136],
  // live_cursor[206:143], replay_cursor[270:207], zero pad
  output logic [obrc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // byte_valid
  output logic                               out_tuser,
  output logic                               out_tlast
);

  import obrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_OUT,
    ST_EMPTY_OUT,
    ST_LAP,
    ST_AVAIL,
    ST_SETUP,
    ST_DRAIN
  } state_t;

  localparam int SUB_W = AVAIL_W + 1;

  state_t state_r, state_nxt;

  logic [CUR_W-1:0]   total_r, total_nxt;
  logic [CUR_W-1:0]   oldest_r, oldest_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [CUR_W-1:0]   lost_r, lost_nxt;
  logic [CUR_W-1:0]   next_r, next_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [AVAIL_W-1:0] avail_lo_r, avail_lo_nxt;
  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic [CNT_W-1:0]   em_r, em_nxt;
  logic               rd_pend_r, rd_pend_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  o_byte_r, o_byte_nxt;
  logic               o_bvalid_r, o_bvalid_nxt;
  logic [CUR_W-1:0]   o_lost_r, o_lost_nxt;
  logic [CUR_W-1:0]   o_next_r, o_next_nxt;
  logic [CNT_W-1:0]   o_copied_r, o_copied_nxt;
  logic               o_last_r, o_last_nxt;
  logic [CUR_W-1:0]   o_live_r, o_live_nxt;
  logic [CUR_W-1:0]   o_replay_r, o_replay_nxt;

  logic [BYTE_W-1:0]  in_byte;
  logic [CUR_W-1:0]   in_cursor;
  logic [CNT_W-1:0]   in_max;

  logic               accept;
  logic               out_free;
  logic               mem_we;
  logic               mem_re;
  logic [BYTE_W-1:0]  mem_rdata;

  logic [CUR_W-1:0]   avail;
  logic               avail_small;
  logic [SUB_W-1:0]   start_diff;
  logic               issue;
  logic               take;
  logic               last_beat;

  assign in_byte   = in_tdata[BYTE_W-1:0];
  assign in_cursor = in_tdata[BYTE_W+CUR_W-1:BYTE_W];
  assign in_max    = in_tdata[BYTE_W+CUR_W+CNT_W-1:BYTE_W+CUR_W];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign avail       = total_r - cur_r;
  assign avail_small = (avail[CUR_W-1:CNT_W] == '0) && (avail[CNT_W-1:0] < lim_r);
  assign start_diff  = SUB_W'(wr_addr_r) - SUB_W'(avail_lo_r);

  assign issue     = (state_r == ST_DRAIN) && (iss_r != count_r) && (!rd_pend_r || out_free);
  assign take      = (state_r == ST_DRAIN) && rd_pend_r && out_free;
  assign last_beat = ((em_r + CNT_W'(1)) == count_r);

  assign mem_we = accept && (in_tuser == FUNC_PUSH);
  assign mem_re = issue;

  obrc_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr_r),
    .wdata (in_byte),
    .re    (mem_re),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    oldest_nxt   = oldest_r;
    wr_addr_nxt  = wr_addr_r;
    cur_nxt      = cur_r;
    lost_nxt     = lost_r;
    next_nxt     = next_r;
    lim_nxt      = lim_r;
    count_nxt    = count_r;
    avail_lo_nxt = avail_lo_r;
    rd_addr_nxt  = rd_addr_r;
    iss_nxt      = iss_r;
    em_nxt       = em_r;
    rd_pend_nxt  = rd_pend_r;

    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    o_byte_nxt    = o_byte_r;
    o_bvalid_nxt  = o_bvalid_r;
    o_lost_nxt    = o_lost_r;
    o_next_nxt    = o_next_r;
    o_copied_nxt  = o_copied_r;
    o_last_nxt    = o_last_r;
    o_live_nxt    = o_live_r;
    o_replay_nxt  = o_replay_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == FUNC_PUSH) begin
            total_nxt = total_r + CUR_W'(1);
            // oldest held = total after push - CAPACITY, once total exceeds CAPACITY
            if ((total_r >= CUR_W'(CAPACITY)) && (total_r != '1)) begin
              oldest_nxt = total_r - CUR_W'(CAPACITY - 1);
            end else begin
              oldest_nxt = '0;
            end
            if (wr_addr_r == ADDR_W'(CAPACITY - 1)) begin
              wr_addr_nxt = '0;
            end else begin
              wr_addr_nxt = wr_addr_r + ADDR_W'(1);
            end
            state_nxt = ST_PUSH_OUT;
          end else begin
            cur_nxt  = in_cursor;
            lost_nxt = '0;
            lim_nxt  = (in_max > CNT_W'(MAX_DRAIN)) ? CNT_W'(MAX_DRAIN) : in_max;
            state_nxt = (in_max == '0) ? ST_EMPTY_OUT : ST_LAP;
          end
        end
      end

      ST_PUSH_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_byte_nxt    = '0;
          o_bvalid_nxt  = 1'b0;
          o_lost_nxt    = '0;
          o_next_nxt    = '0;
          o_copied_nxt  = '0;
          o_last_nxt    = 1'b1;
          o_live_nxt    = total_r;
          o_replay_nxt  = oldest_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_EMPTY_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_byte_nxt    = '0;
          o_bvalid_nxt  = 1'b0;
          o_lost_nxt    = lost_r;
          o_next_nxt    = cur_r;
          o_copied_nxt  = '0;
          o_last_nxt    = 1'b1;
          o_live_nxt    = total_r;
          o_replay_nxt  = oldest_r;
          state_nxt     = ST_IDLE;
        end
      end

      ST_LAP: begin
        // lapped reader snaps to the oldest held byte
        if (cur_r < oldest_r) begin
          lost_nxt = oldest_r - cur_r;
          cur_nxt  = oldest_r;
        end
        state_nxt = ST_AVAIL;
      end

      ST_AVAIL: begin
        if (cur_r > total_r) begin
          count_nxt = '0;
        end else if (avail_small) begin
          count_nxt = avail[CNT_W-1:0];
        end else begin
          count_nxt = lim_r;
        end
        // only meaningful when bytes are available, then avail <= CAPACITY
        avail_lo_nxt = avail[AVAIL_W-1:0];
        state_nxt    = ST_AVAIL == state_r ? ST_SETUP : state_r;
      end

      ST_SETUP: begin
        if (count_r == '0) begin
          state_nxt = ST_EMPTY_OUT;
        end else begin
          next_nxt = cur_r + CUR_W'(count_r);
          // first slot sits avail bytes behind the write pointer
          if (start_diff[SUB_W-1]) begin
            rd_addr_nxt = ADDR_W'(start_diff + SUB_W'(CAPACITY));
          end else begin
            rd_addr_nxt = ADDR_W'(start_diff);
          end
          iss_nxt     = '0;
          em_nxt      = '0;
          rd_pend_nxt = 1'b0;
          state_nxt   = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (issue) begin
          iss_nxt = iss_r + CNT_W'(1);
          if (rd_addr_r == ADDR_W'(CAPACITY - 1)) begin
            rd_addr_nxt = '0;
          end else begin
            rd_addr_nxt = rd_addr_r + ADDR_W'(1);
          end
        end
        rd_pend_nxt = issue || (rd_pend_r && !out_free);
        if (take) begin
          out_valid_nxt = 1'b1;
          o_byte_nxt    = mem_rdata;
          o_bvalid_nxt  = 1'b1;
          o_lost_nxt    = lost_r;
          o_next_nxt    = next_r;
          o_copied_nxt  = count_r;
          o_last_nxt    = last_beat;
          o_live_nxt    = total_r;
          o_replay_nxt  = oldest_r;
          em_nxt        = em_r + CNT_W'(1);
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      oldest_r    <= '0;
      wr_addr_r   <= '0;
      iss_r       <= '0;
      em_r        <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      oldest_r    <= oldest_nxt;
      wr_addr_r   <= wr_addr_nxt;
      iss_r       <= iss_nxt;
      em_r        <= em_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    lost_r     <= lost_nxt;
    next_r     <= next_nxt;
    lim_r      <= lim_nxt;
    count_r    <= count_nxt;
    avail_lo_r <= avail_lo_nxt;
    rd_addr_r  <= rd_addr_nxt;
    o_byte_r   <= o_byte_nxt;
    o_bvalid_r <= o_bvalid_nxt;
    o_lost_r   <= o_lost_nxt;
    o_next_r   <= o_next_nxt;
    o_copied_r <= o_copied_nxt;
    o_last_r   <= o_last_nxt;
    o_live_r   <= o_live_nxt;
    o_replay_r <= o_replay_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_bvalid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), o_replay_r, o_live_r, o_copied_r,
                       o_next_r, o_lost_r, o_byte_r};

endmodule

// ----- sim/overwriting_byte_ring_with_cursors_tb.sv -----
`timescale 1ns / 1ps

module overwriting_byte_ring_with_cursors_tb;
  import obrc_pkg::*;

  localparam int LOST_LO   = BYTE_W;
  localparam int NEXT_LO   = LOST_LO + CUR_W;
  localparam int COPIED_LO = NEXT_LO + CUR_W;
  localparam int LIVE_LO   = COPIED_LO + CNT_W;
  localparam int REPLAY_LO = LIVE_LO + CUR_W;
  localparam int DRAIN_TAIL_CYCLES = 20;
  localparam int WATCHDOG_LIMIT    = 2000;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic [CUR_W-1:0]  lost;
    logic [CUR_W-1:0]  next_cur;
    logic [CNT_W-1:0]  copied;
    logic              last;
    logic [CUR_W-1:0]  live;
    logic [CUR_W-1:0]  replay;
  } ring_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // predictor state
  logic [BYTE_W-1:0] ring_model [CAPACITY];
  logic [CUR_W-1:0]  bytes_pushed;
  ring_beat_t        expected_beats [$];

  bit quiet;
  int errors;
  int push_count;
  int drain_count;
  int beats_checked;
  int stall_left;
  int idle_cycles;

  always #10 clk = ~clk;

  overwriting_byte_ring_with_cursors dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic logic [CUR_W-1:0] oldest_held();
    return (bytes_pushed > 64'(CAPACITY)) ? bytes_pushed - 64'(CAPACITY) : '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [CUR_W-1:0] got,
                                 input logic [CUR_W-1:0] want);
    $display("[%0t] mismatch at result beat %0d: %s got %h expected %h",
             $time, beats_checked, what, got, want);
    errors++;
  endtask

  // Works out the result beats of one accepted item and queues them.
  task automatic ring_predict(input logic func, input logic [BYTE_W-1:0] data,
                              input logic [CUR_W-1:0] cursor,
                              input logic [CNT_W-1:0] limit);
    ring_beat_t       b;
    logic [CUR_W-1:0] lost;
    logic [CUR_W-1:0] avail;
    logic [CUR_W-1:0] count;
    logic [CUR_W-1:0] cur;
    logic [CUR_W-1:0] slot;
    b = '{default: '0};
    b.last = 1'b1;
    if (func == FUNC_PUSH) begin
      slot = bytes_pushed % 64'(CAPACITY);
      ring_model[slot[ADDR_W-1:0]] = data;
      bytes_pushed = bytes_pushed + CUR_W'(1);
      b.live = bytes_pushed;
      b.replay = oldest_held();
      expected_beats.push_back(b);
      return;
    end
    b.live = bytes_pushed;
    b.replay = oldest_held();
    if (limit == '0) begin
      // zero limit: cursor echoed as given, no snap
      b.next_cur = cursor;
      expected_beats.push_back(b);
      return;
    end
    if (limit > CNT_W'(MAX_DRAIN)) limit = CNT_W'(MAX_DRAIN);
    cur = cursor;
    lost = '0;
    if (cur < oldest_held()) begin
      lost = oldest_held() - cur;
      cur = oldest_held();
    end
    avail = (cur <= bytes_pushed) ? bytes_pushed - cur : '0;
    count = (avail < 64'(limit)) ? avail : 64'(limit);
    b.lost = lost;
    if (count == '0) begin
      b.next_cur = cur;
      expected_beats.push_back(b);
      return;
    end
    for (logic [CUR_W-1:0] i = '0; i < count; i++) begin
      slot = (cur + i) % 64'(CAPACITY);
      b.data = ring_model[slot[ADDR_W-1:0]];
      b.valid = 1'b1;
      b.next_cur = cur + count;
      b.copied = CNT_W'(count);
      b.last = (i + CUR_W'(1) == count);
      expected_beats.push_back(b);
    end
  endtask

  // Caller is always at a rising edge; valid stays high after the accept so
  // back-to-back items need no second assignment in one step.
  task automatic send_item(input logic func, input logic [BYTE_W-1:0] data,
                           input logic [CUR_W-1:0] cursor,
                           input logic [CNT_W-1:0] limit);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[0 +: BYTE_W] = data;
    beat[BYTE_W +: CUR_W] = cursor;
    beat[BYTE_W + CUR_W +: CNT_W] = limit;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    ring_predict(func, data, cursor, limit);
    if (func == FUNC_PUSH) push_count++;
    else drain_count++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] data);
    send_item(FUNC_PUSH, data, {$urandom, $urandom}, CNT_W'($urandom));
  endtask

  task automatic drain(input logic [CUR_W-1:0] cursor, input logic [CNT_W-1:0] limit);
    send_item(FUNC_DRAIN, BYTE_W'($urandom), cursor, limit);
  endtask

  task automatic random_item();
    logic [CUR_W-1:0] cur;
    logic [CNT_W-1:0] lim;
    int pick;
    if ($urandom_range(0, 1) == 0) begin
      push_byte(BYTE_W'($urandom));
      return;
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: cur = bytes_pushed - CUR_W'($urandom_range(0, 80));
      4, 5:       cur = oldest_held() - CUR_W'($urandom_range(1, 200));
      6:          cur = oldest_held();
      7:          cur = {$urandom, $urandom};
      8:          cur = bytes_pushed + CUR_W'($urandom_range(1, 100));
      default:    cur = bytes_pushed;
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 0) lim = '0;
    else if (pick == 1) lim = CNT_W'($urandom_range(MAX_DRAIN + 1, 127));
    else lim = CNT_W'($urandom_range(1, MAX_DRAIN));
    drain(cur, lim);
  endtask

  task automatic test_empty_ring();
    drain(64'd0, 7'd0);
    drain(64'd0, 7'd1);
    drain(64'd5, 7'd64);
    drain('1, 7'd127);
  endtask

  task automatic test_push_and_drain();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_byte(8'h3C);
    drain(64'd0, 7'd127);      // limit saturates, all five bytes
    drain(64'd2, 7'd1);
    drain(bytes_pushed, 7'd10); // caught up, nothing available
    drain(64'd3, 7'd0);
    drain(64'h8000_0000_0000_0000, 7'd64);
  endtask

  task automatic test_random_mix();
    repeat (70) random_item();
  endtask

  task automatic test_full_rate_tail();
    quiet = 1'b1;
    repeat (30) random_item();
  endtask

  // result side: random stall bursts, none started in the tail
  always @(posedge clk) begin
    logic ready;
    ready = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      ready = 1'b0;
    end
    out_tready <= ready;
  end

  always @(posedge clk) begin
    ring_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", out_tdata[REPLAY_LO +: CUR_W], '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[0 +: BYTE_W] !== want.data)
          report_mismatch("out_byte", CUR_W'(out_tdata[0 +: BYTE_W]), CUR_W'(want.data));
        if (out_tuser !== want.valid)
          report_mismatch("byte_valid", CUR_W'(out_tuser), CUR_W'(want.valid));
        if (out_tdata[LOST_LO +: CUR_W] !== want.lost)
          report_mismatch("lost_count", out_tdata[LOST_LO +: CUR_W], want.lost);
        if (out_tdata[NEXT_LO +: CUR_W] !== want.next_cur)
          report_mismatch("next_cursor", out_tdata[NEXT_LO +: CUR_W], want.next_cur);
        if (out_tdata[COPIED_LO +: CNT_W] !== want.copied)
          report_mismatch("bytes_copied", CUR_W'(out_tdata[COPIED_LO +: CNT_W]),
                          CUR_W'(want.copied));
        if (out_tlast !== want.last)
          report_mismatch("last", CUR_W'(out_tlast), CUR_W'(want.last));
        if (out_tdata[LIVE_LO +: CUR_W] !== want.live)
          report_mismatch("live_cursor", out_tdata[LIVE_LO +: CUR_W], want.live);
        if (out_tdata[REPLAY_LO +: CUR_W] !== want.replay)
          report_mismatch("replay_cursor", out_tdata[REPLAY_LO +: CUR_W], want.replay);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_beats.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    bytes_pushed = '0;
    quiet        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_push_and_drain();
    test_random_mix();
    test_full_rate_tail();

    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d pushes and %0d drains: empty ring, zero and oversized limits,",
             push_count, drain_count);
    $display("cursors behind, at and ahead of the write count; %0d beats, %0d mismatches",
             beats_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
